FILE: rtl/msbf_pkg.sv
// Shared types, codes and default sizes for the message slot with backlog FIFO.
package msbf_pkg;

    localparam int SLOT_BYTES_DEF    = 64;
    localparam int BACKLOG_BYTES_DEF = 256;

    typedef enum logic [1:0] {
        ACT_ADD   = 2'd0,
        ACT_NEXT  = 2'd1,
        ACT_FLUSH = 2'd2,
        ACT_READ  = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_OK           = 2'd0,
        ST_TOO_LONG     = 2'd1,
        ST_BACKLOG_FULL = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        TGT_SLOT      = 2'd0,
        TGT_BACKLOG   = 2'd1,
        TGT_DROP_LONG = 2'd2,
        TGT_DROP_FULL = 2'd3
    } target_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADD_HEAD,
        S_ADD_DATA,
        S_NEXT_SIZE,
        S_COPY_RD,
        S_COPY_WR,
        S_READ_WAIT,
        S_FINISH
    } state_t;

    typedef struct packed {
        action_t     action;
        logic [7:0]  msg_length;
        logic [7:0]  data_byte;
        logic [5:0]  read_index;
    } req_item_t;

    typedef struct packed {
        status_t     status;
        logic [7:0]  read_data;
        logic [6:0]  current_length;
        logic        message_ready;
        logic [8:0]  backlog_used;
    } rsp_item_t;

endpackage

FILE: rtl/message_slot_with_backlog_fifo.sv
// Top level: message slot with length-prefixed backlog FIFO and its sequencer.
//
// Requests enter on req_valid/req_ready with a req_item payload; one response
// per request leaves on rsp_valid/rsp_ready with a rsp_item payload.
// req_ready is high only while the sequencer is idle; one request is worked
// at a time. An add byte goes through S_ADD_HEAD and S_ADD_DATA (an ignored
// zero-length add skips S_ADD_DATA), a read through S_READ_WAIT; a flush, and
// a next that is ignored or clears the slot, go straight to S_FINISH. Any
// other next reads the popped length in S_NEXT_SIZE and copies n bytes (n at
// most SLOT_BYTES), S_COPY_RD then S_COPY_WR for each, as the single backlog
// read port feeds the single slot write port. req_ready rises at the edge that
// loads the response, so no request is accepted before that response is valid.
// The response sits in an output register; a new request is taken while it
// waits. When the receiver stalls, the next response holds in the finish
// state until the output register frees up.
// Reset clears the slot (valid bits), slot length, backlog pointers and
// count, and the message in progress; it takes effect at once, with no
// clearing pass. Backlog contents are not cleared and are only read once
// written.
module message_slot_with_backlog_fifo
    import msbf_pkg::*;
#(
    parameter int SLOT_BYTES    = SLOT_BYTES_DEF,
    parameter int BACKLOG_BYTES = BACKLOG_BYTES_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    input  req_item_t req_item,
    output logic      rsp_valid,
    input  logic      rsp_ready,
    output rsp_item_t rsp_item
);

    localparam int SW = $clog2(SLOT_BYTES);
    localparam int LW = $clog2(SLOT_BYTES + 1);
    localparam int HW = $clog2(BACKLOG_BYTES);
    localparam int CW = $clog2(BACKLOG_BYTES + 1);
    localparam int MW = ((CW > 8) ? CW : 8) + 1;
    localparam int RW = (SW > 6) ? SW : 6;

    state_t          state_reg, state_next;
    logic [7:0]      len_reg, len_next;
    logic [7:0]      data_reg, data_next;
    logic [LW-1:0]   slot_length_reg, slot_length_next;
    logic [HW-1:0]   head_reg, head_next;
    logic [HW-1:0]   tail_reg, tail_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [7:0]      bytes_seen_reg, bytes_seen_next;
    target_t         target_reg, target_next;
    logic [7:0]      latched_reg, latched_next;
    logic [SW-1:0]   copy_idx_reg, copy_idx_next;
    logic [LW-1:0]   copy_left_reg, copy_left_next;
    status_t         status_reg, status_next;
    logic [7:0]      rdata_reg, rdata_next;
    logic            ridx_ok_reg, ridx_ok_next;
    logic            rsp_valid_reg, rsp_valid_next;
    rsp_item_t       rsp_item_reg;

    logic            req_accept;
    logic            rsp_load;
    logic [HW-1:0]   head_inc;
    logic [HW-1:0]   tail_inc;
    logic            room_ok;
    logic            too_long;
    logic            seen_done;
    logic [MW-1:0]   pop_len;
    logic [MW-1:0]   pop_clamp;
    logic [RW-1:0]   ridx_ext;
    logic            ridx_ok;

    logic            slot_clear;
    logic            slot_we;
    logic [SW-1:0]   slot_waddr;
    logic [7:0]      slot_wdata;
    logic            slot_re;
    logic [7:0]      slot_rdata;
    logic            bl_we;
    logic [7:0]      bl_wdata;
    logic            bl_re;
    logic [7:0]      bl_rdata;

    msbf_slot_mem #(
        .SLOT_BYTES (SLOT_BYTES)
    ) u_slot (
        .clk   (clk),
        .rst_n (rst_n),
        .clear (slot_clear),
        .we    (slot_we),
        .waddr (slot_waddr),
        .wdata (slot_wdata),
        .re    (slot_re),
        .raddr (ridx_ext[SW-1:0]),
        .rdata (slot_rdata)
    );

    msbf_backlog_mem #(
        .BACKLOG_BYTES (BACKLOG_BYTES)
    ) u_backlog (
        .clk   (clk),
        .we    (bl_we),
        .waddr (tail_reg),
        .wdata (bl_wdata),
        .re    (bl_re),
        .raddr (head_reg),
        .rdata (bl_rdata)
    );

    assign req_ready  = (state_reg == S_IDLE);
    assign req_accept = req_valid && req_ready;

    assign head_inc = (head_reg == HW'(BACKLOG_BYTES - 1)) ? '0 : head_reg + 1'b1;
    assign tail_inc = (tail_reg == HW'(BACKLOG_BYTES - 1)) ? '0 : tail_reg + 1'b1;

    assign room_ok   = (MW'(count_reg) + MW'(len_reg) + MW'(1)) <= MW'(BACKLOG_BYTES);
    assign too_long  = MW'(len_reg) > MW'(SLOT_BYTES);
    assign seen_done = ({1'b0, bytes_seen_reg} + 9'd1) >= {1'b0, latched_reg};

    assign ridx_ext = RW'(req_item.read_index);
    assign ridx_ok  = MW'(req_item.read_index) < MW'(SLOT_BYTES);

    always_comb
    begin
        pop_len = MW'(bl_rdata);
        if (pop_len > MW'(SLOT_BYTES))
        begin
            pop_len = MW'(SLOT_BYTES);
        end
        pop_clamp = (pop_len > MW'(count_reg)) ? MW'(count_reg) : pop_len;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_accept)
                begin
                    case (req_item.action)
                        ACT_ADD:   state_next = S_ADD_HEAD;
                        ACT_NEXT:  state_next = (bytes_seen_reg == 8'd0 && count_reg != '0)
                                                ? S_NEXT_SIZE : S_FINISH;
                        ACT_READ:  state_next = S_READ_WAIT;
                        default:   state_next = S_FINISH;
                    endcase
                end
            end
            S_ADD_HEAD:
            begin
                state_next = (bytes_seen_reg == 8'd0 && len_reg == 8'd0)
                             ? S_FINISH : S_ADD_DATA;
            end
            S_ADD_DATA:  state_next = S_FINISH;
            S_NEXT_SIZE: state_next = (pop_clamp == '0) ? S_FINISH : S_COPY_RD;
            S_COPY_RD:   state_next = S_COPY_WR;
            S_COPY_WR:   state_next = (copy_left_reg == LW'(1)) ? S_FINISH : S_COPY_RD;
            S_READ_WAIT: state_next = S_FINISH;
            S_FINISH:    state_next = (!rsp_valid_reg || rsp_ready) ? S_IDLE : S_FINISH;
            default:     state_next = S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        len_next         = len_reg;
        data_next        = data_reg;
        slot_length_next = slot_length_reg;
        head_next        = head_reg;
        tail_next        = tail_reg;
        count_next       = count_reg;
        bytes_seen_next  = bytes_seen_reg;
        target_next      = target_reg;
        latched_next     = latched_reg;
        copy_idx_next    = copy_idx_reg;
        copy_left_next   = copy_left_reg;
        status_next      = status_reg;
        rdata_next       = rdata_reg;
        ridx_ok_next     = ridx_ok_reg;
        slot_clear       = 1'b0;
        slot_we          = 1'b0;
        slot_waddr       = bytes_seen_reg[SW-1:0];
        slot_wdata       = data_reg;
        slot_re          = 1'b0;
        bl_we            = 1'b0;
        bl_wdata         = data_reg;
        bl_re            = 1'b0;
        rsp_load         = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (req_accept)
                begin
                    len_next     = req_item.msg_length;
                    data_next    = req_item.data_byte;
                    ridx_ok_next = ridx_ok;
                    status_next  = ST_OK;
                    rdata_next   = 8'd0;
                    case (req_item.action)
                        ACT_NEXT:
                        begin
                            if (bytes_seen_reg == 8'd0)
                            begin
                                if (count_reg != '0)
                                begin
                                    bl_re      = 1'b1;
                                    head_next  = head_inc;
                                    count_next = count_reg - 1'b1;
                                end
                                else
                                begin
                                    slot_length_next = '0;
                                    slot_clear       = 1'b1;
                                end
                            end
                        end
                        ACT_FLUSH:
                        begin
                            head_next        = '0;
                            tail_next        = '0;
                            count_next       = '0;
                            slot_length_next = '0;
                            slot_clear       = 1'b1;
                            bytes_seen_next  = 8'd0;
                            target_next      = TGT_SLOT;
                            latched_next     = 8'd0;
                        end
                        ACT_READ:
                        begin
                            slot_re = 1'b1;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_ADD_HEAD:
            begin
                if (bytes_seen_reg == 8'd0 && len_reg != 8'd0)
                begin
                    latched_next = len_reg;
                    if (too_long)
                    begin
                        target_next = TGT_DROP_LONG;
                    end
                    else if (slot_length_reg == '0)
                    begin
                        target_next = TGT_SLOT;
                    end
                    else if (room_ok)
                    begin
                        target_next = TGT_BACKLOG;
                        bl_we       = 1'b1;
                        bl_wdata    = len_reg;
                        tail_next   = tail_inc;
                        count_next  = count_reg + 1'b1;
                    end
                    else
                    begin
                        target_next = TGT_DROP_FULL;
                    end
                end
            end
            S_ADD_DATA:
            begin
                case (target_reg)
                    TGT_SLOT:
                    begin
                        slot_we = 1'b1;
                    end
                    TGT_BACKLOG:
                    begin
                        bl_we      = 1'b1;
                        tail_next  = tail_inc;
                        count_next = count_reg + 1'b1;
                    end
                    TGT_DROP_LONG: status_next = ST_TOO_LONG;
                    TGT_DROP_FULL: status_next = ST_BACKLOG_FULL;
                    default:       status_next = ST_OK;
                endcase
                bytes_seen_next = bytes_seen_reg + 8'd1;
                if (seen_done)
                begin
                    if (target_reg == TGT_SLOT)
                    begin
                        slot_length_next = LW'(latched_reg);
                    end
                    bytes_seen_next = 8'd0;
                end
            end
            S_NEXT_SIZE:
            begin
                slot_length_next = LW'(pop_clamp);
                copy_left_next   = LW'(pop_clamp);
                copy_idx_next    = '0;
            end
            S_COPY_RD:
            begin
                bl_re      = 1'b1;
                head_next  = head_inc;
                count_next = count_reg - 1'b1;
            end
            S_COPY_WR:
            begin
                slot_we        = 1'b1;
                slot_waddr     = copy_idx_reg;
                slot_wdata     = bl_rdata;
                copy_idx_next  = copy_idx_reg + 1'b1;
                copy_left_next = copy_left_reg - 1'b1;
            end
            S_READ_WAIT:
            begin
                rdata_next = ridx_ok_reg ? slot_rdata : 8'd0;
            end
            S_FINISH:
            begin
                rsp_load = !rsp_valid_reg || rsp_ready;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        if (rsp_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            slot_length_reg <= '0;
            head_reg        <= '0;
            tail_reg        <= '0;
            count_reg       <= '0;
            bytes_seen_reg  <= 8'd0;
            target_reg      <= TGT_SLOT;
            latched_reg     <= 8'd0;
            copy_idx_reg    <= '0;
            copy_left_reg   <= '0;
            rsp_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            slot_length_reg <= slot_length_next;
            head_reg        <= head_next;
            tail_reg        <= tail_next;
            count_reg       <= count_next;
            bytes_seen_reg  <= bytes_seen_next;
            target_reg      <= target_next;
            latched_reg     <= latched_next;
            copy_idx_reg    <= copy_idx_next;
            copy_left_reg   <= copy_left_next;
            rsp_valid_reg   <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg     <= len_next;
        data_reg    <= data_next;
        status_reg  <= status_next;
        rdata_reg   <= rdata_next;
        ridx_ok_reg <= ridx_ok_next;
        if (rsp_load)
        begin
            rsp_item_reg.status         <= status_reg;
            rsp_item_reg.read_data      <= rdata_reg;
            rsp_item_reg.current_length <= 7'(slot_length_reg);
            rsp_item_reg.message_ready  <= (slot_length_reg != '0);
            rsp_item_reg.backlog_used   <= 9'(count_reg);
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_item  = rsp_item_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(BACKLOG_BYTES))
        else $error("backlog count exceeds capacity");

    a_slot_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        slot_length_reg <= LW'(SLOT_BYTES))
        else $error("slot length exceeds slot size");

    a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == '0 |-> head_reg == tail_reg)
        else $error("empty backlog with unequal pointers");

    a_rsp_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == S_FINISH))
        else $error("response raised outside finish state");

    a_copy_left: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_COPY_RD || state_reg == S_COPY_WR) |-> copy_left_reg != '0)
        else $error("copy loop running with nothing left");

endmodule

FILE: rtl/msbf_slot_mem.sv
// Current-message slot storage with per-entry valid bits that read as zero when clear.
module msbf_slot_mem
    import msbf_pkg::*;
#(
    parameter int SLOT_BYTES = SLOT_BYTES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          clear,
    input  logic                          we,
    input  logic [$clog2(SLOT_BYTES)-1:0] waddr,
    input  logic [7:0]                    wdata,
    input  logic                          re,
    input  logic [$clog2(SLOT_BYTES)-1:0] raddr,
    output logic [7:0]                    rdata
);

    logic [7:0]            slot_mem_reg [SLOT_BYTES];
    logic [SLOT_BYTES-1:0] valid_reg;
    logic [7:0]            rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            slot_mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= valid_reg[raddr] ? slot_mem_reg[raddr] : 8'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (clear)
        begin
            valid_reg <= '0;
        end
        else if (we)
        begin
            valid_reg[waddr] <= 1'b1;
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/msbf_backlog_mem.sv
// Backlog byte storage: one write port and one registered read port.
module msbf_backlog_mem
    import msbf_pkg::*;
#(
    parameter int BACKLOG_BYTES = BACKLOG_BYTES_DEF
) (
    input  logic                             clk,
    input  logic                             we,
    input  logic [$clog2(BACKLOG_BYTES)-1:0] waddr,
    input  logic [7:0]                       wdata,
    input  logic                             re,
    input  logic [$clog2(BACKLOG_BYTES)-1:0] raddr,
    output logic [7:0]                       rdata
);

    logic [7:0] backlog_mem_reg [BACKLOG_BYTES];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            backlog_mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= backlog_mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
